// File: rtl/dq_pkg.sv
package dq_pkg;

	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_PEEK = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic        at_front;
		logic [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic [31:0] out_value;
		logic [1:0]  status;
		logic [4:0]  fill_count;
	} rsp_t;

	typedef struct packed {
		logic push_front;
		logic pop_front;
		logic push_back;
		logic pop_back;
	} cell_cmd_t;

endpackage

// File: rtl/double_ended_queue.sv
// Channel  Direction  Handshake               Payload
// req      input      req_valid / req_stall   req_t  (action, at_front, push_value)
// rsp      output     rsp_valid / rsp_stall   rsp_t  (out_value, status, fill_count)
//
// An accepted request's response sits in the output register the cycle after.
// The queue lives in a row of DEPTH cells; front pushes and pops shift them together, so the front is always cell 0.
// Reset clears the occupancy flags and the count; stored words need no reset.
// A new request is taken while the previous response is being taken on the same edge.
// req_stall is high only while an unaccepted response waits in the output register.
module double_ended_queue
	import dq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         next_count;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	logic                  accept;
	logic                  full;
	logic                  empty;
	logic [DATA_WIDTH-1:0] word;
	logic [DATA_WIDTH-1:0] back_data;
	logic [DATA_WIDTH-1:0] value;
	logic [1:0]            status;
	cell_cmd_t             cmd;
	cell_cmd_t             cell_cmd;

	logic                  occ      [DEPTH];
	logic [DATA_WIDTH-1:0] cdata    [DEPTH];
	logic [DATA_WIDTH-1:0] tail     [DEPTH];

	assign req_stall = rsp_valid_q & rsp_stall;
	assign accept    = req_valid & ~req_stall;
	assign full      = count_q == CW'(DEPTH);
	assign empty     = count_q == '0;
	assign word      = DATA_WIDTH'(req.push_value);

	always_comb begin
		back_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_data = back_data | tail[i];
		end
	end

	always_comb begin
		cmd        = '0;
		value      = '0;
		status     = ST_OK;
		next_count = count_q;
		case (req.action)
			ACT_PUSH: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					cmd.push_front = req.at_front;
					cmd.push_back  = ~req.at_front;
					value          = word;
					next_count     = count_q + 1'b1;
				end
			end
			ACT_POP, ACT_PEEK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					value = req.at_front ? cdata[0] : back_data;
					if (req.action == ACT_POP) begin
						cmd.pop_front = req.at_front;
						cmd.pop_back  = ~req.at_front;
						next_count    = count_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign cell_cmd = accept ? cmd : '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  l_occ;
		logic                  r_occ;
		logic [DATA_WIDTH-1:0] l_data;
		logic [DATA_WIDTH-1:0] r_data;

		if (i == 0) begin : g_first
			assign l_occ  = 1'b1;
			assign l_data = word;
		end else begin : g_mid_l
			assign l_occ  = occ[i-1];
			assign l_data = cdata[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_occ  = 1'b0;
			assign r_data = '0;
		end else begin : g_mid_r
			assign r_occ  = occ[i+1];
			assign r_data = cdata[i+1];
		end

		dq_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cell_cmd),
			.push_word  (word),
			.left_occ   (l_occ),
			.left_data  (l_data),
			.right_occ  (r_occ),
			.right_data (r_data),
			.occ        (occ[i]),
			.data       (cdata[i]),
			.tail_data  (tail[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= next_count;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.out_value  <= 32'(value);
			rsp_q.status     <= status;
			rsp_q.fill_count <= 5'(next_count);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == !occ[0])
		else $error("front cell occupancy disagrees with count");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CW'(DEPTH)) == occ[DEPTH-1])
		else $error("last cell occupancy disagrees with count");

	a_rsp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted request left no response");

endmodule

// File: rtl/dq_cell.sv
module dq_cell
	import dq_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_cmd_t             cmd,
	input  logic [DATA_WIDTH-1:0] push_word,
	input  logic                  left_occ,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic                  right_occ,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic                  occ,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] tail_data
);

	logic                  occ_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic                  take_back;
	logic                  drop_back;

	assign take_back = cmd.push_back & left_occ & ~occ_q;
	assign drop_back = cmd.pop_back & occ_q & ~right_occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.push_front) begin
			occ_q <= left_occ;
		end else if (cmd.pop_front) begin
			occ_q <= right_occ;
		end else if (take_back) begin
			occ_q <= 1'b1;
		end else if (drop_back) begin
			occ_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			data_q <= left_data;
		end else if (cmd.pop_front) begin
			data_q <= right_data;
		end else if (take_back) begin
			data_q <= push_word;
		end
	end

	assign occ       = occ_q;
	assign data      = data_q;
	assign tail_data = (occ_q && !right_occ) ? data_q : '0;

endmodule

// File: test/tb_double_ended_queue.sv
`timescale 1ns / 1ps

module tb_double_ended_queue;
	import dq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	logic [31:0] slot_word [QUEUE_DEPTH];
	logic [3:0] head_slot = '0;
	logic [4:0] entry_total = '0;
	rsp_t predicted_rsp_q [$];

	int mismatch_count = 0;
	int quiet_cycles = 0;
	int hold_request = 0;
	bit send_gaps_on = 1'b1;
	bit recv_gaps_on = 1'b1;

	double_ended_queue i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one request to the deque copy and returns the response it must produce.
	function automatic rsp_t deque_apply(req_t r);
		rsp_t res;
		logic [3:0] slot;
		res = '0;
		case (r.action)
			ACT_PUSH: begin
				if (entry_total == QUEUE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					if (r.at_front) begin
						head_slot = head_slot - 1'b1;
						slot = head_slot;
					end else begin
						slot = head_slot + entry_total[3:0];
					end
					slot_word[slot] = r.push_value;
					entry_total = entry_total + 1'b1;
					res.out_value = r.push_value;
				end
			end
			ACT_POP, ACT_PEEK: begin
				if (entry_total == 0) begin
					res.status = ST_EMPTY;
				end else begin
					slot = r.at_front ? head_slot : head_slot + entry_total[3:0] - 1'b1;
					res.out_value = slot_word[slot];
					if (r.action == ACT_POP) begin
						if (r.at_front)
							head_slot = head_slot + 1'b1;
						entry_total = entry_total - 1'b1;
					end
				end
			end
			default: ;
		endcase
		res.fill_count = entry_total;
		return res;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic req_t make_request(logic [1:0] action, logic at_front,
		logic [31:0] value);
		req_t r;
		r.action = action;
		r.at_front = at_front;
		r.push_value = value;
		return r;
	endfunction

	function automatic req_t random_request(int push_pct);
		int roll;
		int pick;
		logic [1:0] action;
		logic [31:0] value;
		roll = $urandom_range(0, 99);
		pick = $urandom_range(0, 9);
		if (roll < 3)
			action = ACT_UNUSED;
		else if (roll < 3 + push_pct)
			action = ACT_PUSH;
		else if ($urandom_range(0, 9) < 7)
			action = ACT_POP;
		else
			action = ACT_PEEK;
		if (pick == 0)
			value = '0;
		else if (pick == 1)
			value = '1;
		else
			value = $urandom;
		return make_request(action, 1'($urandom_range(0, 1)), value);
	endfunction

	// Prediction happens at the accepting edge, checking of each accepted response likewise.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n) begin
			if (req_valid && !req_stall)
				predicted_rsp_q.push_back(deque_apply(req));
			if (rsp_valid && !rsp_stall) begin
				if (predicted_rsp_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected response: value %h status %0d fill %0d",
							rsp.out_value, rsp.status, rsp.fill_count);
				end else begin
					exp_rsp = predicted_rsp_q.pop_front();
					if (rsp.out_value !== exp_rsp.out_value || rsp.status !== exp_rsp.status ||
						rsp.fill_count !== exp_rsp.fill_count) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("mismatch: expected value %h status %0d fill %0d, got value %h status %0d fill %0d",
								exp_rsp.out_value, exp_rsp.status, exp_rsp.fill_count,
								rsp.out_value, rsp.status, rsp.fill_count);
					end
				end
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("== FAIL ==");
					$finish;
				end
			end
		end
	end

	// A long hold-off requested by a test takes precedence over the random stalls.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
				if (recv_gaps_on)
					stall_left = pick_gap();
			end
		end
	end

	task automatic send_request(input req_t item);
		int gap;
		gap = send_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic sender_idle();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (predicted_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_queue();
		send_request(make_request(ACT_POP, 1'b1, '1));
		send_request(make_request(ACT_POP, 1'b0, '0));
		send_request(make_request(ACT_PEEK, 1'b1, 32'h5555_5555));
		send_request(make_request(ACT_PEEK, 1'b0, 32'haaaa_aaaa));
		send_request(make_request(ACT_UNUSED, 1'b1, '1));
	endtask

	task automatic test_fill_to_full();
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			logic [31:0] value;
			case (i)
				0: value = '0;
				1: value = '1;
				2: value = 32'h8000_0000;
				3: value = 32'h0000_0001;
				default: value = $urandom;
			endcase
			send_request(make_request(ACT_PUSH, i[0], value));
		end
		send_request(make_request(ACT_PUSH, 1'b1, 32'hdead_beef));
		send_request(make_request(ACT_PUSH, 1'b0, 32'hcafe_f00d));
		send_request(make_request(ACT_PEEK, 1'b1, '0));
		send_request(make_request(ACT_PEEK, 1'b0, '0));
	endtask

	task automatic test_back_to_back();
		send_gaps_on = 1'b0;
		recv_gaps_on = 1'b0;
		for (int i = 0; i < 100; i++)
			send_request(random_request(i < 50 ? 20 : 60));
		send_gaps_on = 1'b1;
		recv_gaps_on = 1'b1;
	endtask

	task automatic test_receiver_hold();
		send_gaps_on = 1'b0;
		hold_request = 150;
		for (int i = 0; i < 24; i++)
			send_request(random_request(70));
		send_gaps_on = 1'b1;
	endtask

	task automatic test_sender_pause();
		for (int i = 0; i < 30; i++)
			send_request(random_request(50));
		sender_idle();
		wait_drained();
		for (int i = 0; i < 30; i++)
			send_request(random_request(50));
	endtask

	// Batches lean toward pushes or pops, or mix them evenly, so the queue keeps hitting both full and empty.
	task automatic test_random_traffic(input int total);
		int sent;
		int batch;
		int push_pct;
		sent = 0;
		while (sent < total) begin
			case ($urandom_range(0, 2))
				0: push_pct = 15;
				1: push_pct = 50;
				default: push_pct = 85;
			endcase
			batch = $urandom_range(10, 50);
			send_gaps_on = ($urandom_range(0, 3) != 0);
			recv_gaps_on = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < batch && sent < total; i++) begin
				send_request(random_request(push_pct));
				sent++;
			end
		end
		send_gaps_on = 1'b1;
		recv_gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_queue();
		test_fill_to_full();
		test_back_to_back();
		test_receiver_hold();
		test_sender_pause();
		test_random_traffic(1200);

		sender_idle();
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && predicted_rsp_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
